// ===== rtl/imq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_pkg
// Shared types and codes of the indexed min priority queue.
// ----------------------------------------------------------------------------
package imq_pkg;

    localparam int unsigned ID_W     = 10;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned CNT_W    = 10;
    localparam int unsigned ID_SPACE = 1024;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ENTRIES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_KEY        = 1'd1;

    localparam logic signed [KEY_W-1:0] FILL_KEY_RESET = 32'sd100000000;

    localparam logic [2:0] CMD_RELOAD = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_CHANGE = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]  item;
        logic [KEY_W-1:0] key;
    } slot_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SWEEP,
        OP_RELOAD,
        OP_REPORT,
        OP_INS_NEW,
        OP_REMOVE,
        OP_CK_READ,
        OP_CK_START,
        OP_RK_DONE,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_DN_READ,
        OP_DN_MOVE,
        OP_PLACE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] status;
    } ctl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       present;
        logic       len_zero;
        logic       len_one;
        logic       full;
        logic       hole_root;
        logic       no_left;
        logic       up_swap;
        logic       dn_swap;
        logic       key_fell;
        logic       sweep_last;
    } flags_t;

endpackage
`default_nettype wire

// ===== rtl/imq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_datapath
// Heap memory, item map memory, sift registers and result registers.
// ----------------------------------------------------------------------------
module imq_datapath #(
    parameter int unsigned CAPACITY = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [imq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [imq_pkg::CFG_W-1:0]             cfg_data,
    input  wire logic [2:0]                            cmd,
    input  wire logic [imq_pkg::ID_W-1:0]              item_id,
    input  wire logic signed [imq_pkg::KEY_W-1:0]      key_in,
    input  wire imq_pkg::ctl_t                         ctl,
    output imq_pkg::flags_t                            flags,
    output logic [1:0]                                 status,
    output logic [imq_pkg::ID_W-1:0]                   out_item,
    output logic signed [imq_pkg::KEY_W-1:0]           out_key,
    output logic [imq_pkg::CNT_W-1:0]                  entry_count,
    output logic                                       is_empty
);

    localparam int unsigned SLOT_W = $clog2(CAPACITY);
    localparam int unsigned DEPTH  = 1 << SLOT_W;
    localparam int unsigned NW     = (SLOT_W > imq_pkg::ID_W) ? SLOT_W : imq_pkg::ID_W;

    imq_pkg::slot_t heap_mem [DEPTH];
    logic [SLOT_W:0] map_mem [imq_pkg::ID_SPACE];

    logic [2:0]                     cmd_reg;
    logic [imq_pkg::ID_W-1:0]       id_reg;
    logic [imq_pkg::KEY_W-1:0]      key_reg;
    logic [SLOT_W-1:0]              len_reg, len_next;
    logic [SLOT_W-1:0]              n_reg, n_next;
    logic [SLOT_W-1:0]              hole_reg;
    imq_pkg::slot_t                 cur_reg;
    logic [imq_pkg::ID_W-1:0]       sweep_reg, sweep_next;
    logic [SLOT_W:0]                map_rd_reg;
    imq_pkg::slot_t                 a_reg, b_reg;
    logic [imq_pkg::ID_W-1:0]       init_reg;
    logic [imq_pkg::KEY_W-1:0]      fill_reg;
    logic [1:0]                     res_status_reg, res_status_next;
    logic [imq_pkg::ID_W-1:0]       res_item_reg, res_item_next;
    logic [imq_pkg::KEY_W-1:0]      res_key_reg, res_key_next;

    logic [SLOT_W:0]      left, right, len_ext;
    logic                 r_valid, pick_right, sweep_in;
    imq_pkg::slot_t       child;
    logic [SLOT_W-1:0]    child_idx, sat_n;
    logic                 heap_we, map_we, ra_en, rb_en;
    logic [SLOT_W-1:0]    heap_waddr, ra_addr, rb_addr;
    imq_pkg::slot_t       heap_wdata;
    logic [imq_pkg::ID_W-1:0] map_waddr;
    logic [SLOT_W:0]      map_wdata;

    assign left     = {hole_reg, 1'b0};
    assign right    = left + 1'b1;
    assign len_ext  = {1'b0, len_reg};
    assign r_valid  = (right <= len_ext);
    assign pick_right = r_valid && (($signed(a_reg.key) > $signed(b_reg.key)) ||
                        ((a_reg.key == b_reg.key) && !(a_reg.item < b_reg.item)));
    assign child     = pick_right ? b_reg : a_reg;
    assign child_idx = pick_right ? right[SLOT_W-1:0] : left[SLOT_W-1:0];
    assign sweep_in  = (sweep_reg != '0) && (NW'(sweep_reg) <= NW'(n_reg));
    assign sat_n     = (NW'(init_reg) > NW'(CAPACITY - 1)) ? SLOT_W'(CAPACITY - 1)
                                                             : SLOT_W'(init_reg);

    always_comb
    begin
        flags.cmd        = cmd_reg;
        flags.present    = map_rd_reg[SLOT_W];
        flags.len_zero   = (len_reg == '0);
        flags.len_one    = (len_reg == SLOT_W'(1));
        flags.full       = (len_reg == SLOT_W'(CAPACITY - 1));
        flags.hole_root  = (hole_reg == SLOT_W'(1));
        flags.no_left    = (left > len_ext);
        flags.up_swap    = ($signed(cur_reg.key) < $signed(a_reg.key)) ||
                           ((cur_reg.key == a_reg.key) && (cur_reg.item < a_reg.item));
        flags.dn_swap    = ($signed(cur_reg.key) > $signed(child.key));
        flags.key_fell   = ($signed(a_reg.key) > $signed(key_reg));
        flags.sweep_last = (sweep_reg == '1);
    end

    always_comb
    begin
        heap_we    = 1'b0;
        heap_waddr = hole_reg;
        heap_wdata = cur_reg;
        map_we     = 1'b0;
        map_waddr  = cur_reg.item;
        map_wdata  = {1'b1, hole_reg};
        ra_en      = 1'b0;
        ra_addr    = left[SLOT_W-1:0];
        rb_en      = 1'b0;
        rb_addr    = right[SLOT_W-1:0];
        case (ctl.op)
            imq_pkg::OP_ACCEPT:
            begin
                ra_en   = 1'b1;
                ra_addr = SLOT_W'(1);
                rb_en   = 1'b1;
                rb_addr = len_reg;
            end
            imq_pkg::OP_SWEEP:
            begin
                map_we     = 1'b1;
                map_waddr  = sweep_reg;
                map_wdata  = {sweep_in, SLOT_W'(sweep_reg)};
                heap_we    = sweep_in;
                heap_waddr = SLOT_W'(sweep_reg);
                heap_wdata = {sweep_reg, fill_reg};
            end
            imq_pkg::OP_REMOVE:
            begin
                map_we    = 1'b1;
                map_waddr = a_reg.item;
                map_wdata = '0;
            end
            imq_pkg::OP_CK_READ:
            begin
                ra_en   = 1'b1;
                ra_addr = map_rd_reg[SLOT_W-1:0];
            end
            imq_pkg::OP_UP_READ:
            begin
                ra_en   = 1'b1;
                ra_addr = hole_reg >> 1;
            end
            imq_pkg::OP_UP_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wdata = a_reg;
                map_we     = 1'b1;
                map_waddr  = a_reg.item;
            end
            imq_pkg::OP_DN_READ:
            begin
                ra_en = 1'b1;
                rb_en = 1'b1;
            end
            imq_pkg::OP_DN_MOVE:
            begin
                heap_we    = 1'b1;
                heap_wdata = child;
                map_we     = 1'b1;
                map_waddr  = child.item;
            end
            imq_pkg::OP_PLACE:
            begin
                heap_we = 1'b1;
                map_we  = 1'b1;
            end
            default:
            begin
                heap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        if (ra_en)
        begin
            a_reg <= heap_mem[ra_addr];
        end
        if (rb_en)
        begin
            b_reg <= heap_mem[rb_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (ctl.op == imq_pkg::OP_ACCEPT)
        begin
            map_rd_reg <= map_mem[item_id];
        end
    end

    always_comb
    begin
        len_next        = len_reg;
        n_next          = n_reg;
        sweep_next      = sweep_reg;
        res_status_next = res_status_reg;
        res_item_next   = res_item_reg;
        res_key_next    = res_key_reg;
        case (ctl.op)
            imq_pkg::OP_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
            end
            imq_pkg::OP_RELOAD:
            begin
                n_next          = sat_n;
                len_next        = sat_n;
                res_status_next = imq_pkg::ST_OK;
                res_item_next   = '0;
                res_key_next    = '0;
            end
            imq_pkg::OP_REPORT:
            begin
                res_status_next = ctl.status;
                res_item_next   = (ctl.status == imq_pkg::ST_EMPTY) ? '0 : id_reg;
                res_key_next    = '0;
            end
            imq_pkg::OP_INS_NEW, imq_pkg::OP_CK_START:
            begin
                if (ctl.op == imq_pkg::OP_INS_NEW)
                begin
                    len_next = len_reg + 1'b1;
                end
                res_status_next = imq_pkg::ST_OK;
                res_item_next   = id_reg;
                res_key_next    = key_reg;
            end
            imq_pkg::OP_REMOVE:
            begin
                len_next        = len_reg - 1'b1;
                res_status_next = imq_pkg::ST_OK;
                res_item_next   = a_reg.item;
                res_key_next    = a_reg.key;
            end
            imq_pkg::OP_RK_DONE:
            begin
                res_status_next = imq_pkg::ST_OK;
                res_item_next   = id_reg;
                res_key_next    = a_reg.key;
            end
            default:
            begin
                len_next = len_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            n_reg          <= '0;
            sweep_reg      <= '0;
            init_reg       <= '0;
            fill_reg       <= imq_pkg::FILL_KEY_RESET;
            res_status_reg <= imq_pkg::ST_OK;
            res_item_reg   <= '0;
            res_key_reg    <= '0;
        end
        else
        begin
            len_reg        <= len_next;
            n_reg          <= n_next;
            sweep_reg      <= sweep_next;
            res_status_reg <= res_status_next;
            res_item_reg   <= res_item_next;
            res_key_reg    <= res_key_next;
            if (cfg_we && (cfg_index == imq_pkg::CFG_INITIAL_ENTRIES))
            begin
                init_reg <= cfg_data[imq_pkg::ID_W-1:0];
            end
            if (cfg_we && (cfg_index == imq_pkg::CFG_FILL_KEY))
            begin
                fill_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctl.op)
            imq_pkg::OP_ACCEPT:
            begin
                cmd_reg <= cmd;
                id_reg  <= item_id;
                key_reg <= key_in;
            end
            imq_pkg::OP_INS_NEW:
            begin
                hole_reg <= len_reg + 1'b1;
                cur_reg  <= {id_reg, key_reg};
            end
            imq_pkg::OP_REMOVE:
            begin
                hole_reg <= SLOT_W'(1);
                cur_reg  <= b_reg;
            end
            imq_pkg::OP_CK_READ:
            begin
                hole_reg <= map_rd_reg[SLOT_W-1:0];
            end
            imq_pkg::OP_CK_START:
            begin
                cur_reg <= {id_reg, key_reg};
            end
            imq_pkg::OP_UP_MOVE:
            begin
                hole_reg <= hole_reg >> 1;
            end
            imq_pkg::OP_DN_MOVE:
            begin
                hole_reg <= child_idx;
            end
            default:
            begin
                hole_reg <= hole_reg;
            end
        endcase
    end

    assign status      = res_status_reg;
    assign out_item    = res_item_reg;
    assign out_key     = res_key_reg;
    assign entry_count = imq_pkg::CNT_W'(NW'(len_reg));
    assign is_empty    = (len_reg == '0);

endmodule
`default_nettype wire

// ===== rtl/imq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imq_ctrl
// Command sequencer: decode, reload sweep and the up and down sift walks.
// ----------------------------------------------------------------------------
module imq_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire imq_pkg::flags_t flags,
    output imq_pkg::ctl_t        ctl,
    output logic                 busy,
    output logic                 done
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_CK_EVAL,
        S_UP_READ,
        S_UP_EVAL,
        S_DN_READ,
        S_DN_EVAL
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg, fin;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = imq_pkg::OP_NONE;
        ctl.status = imq_pkg::ST_OK;
        fin        = 1'b0;
        case (state_reg)
            S_INIT:
            begin
                ctl.op = imq_pkg::OP_SWEEP;
                if (flags.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op     = imq_pkg::OP_ACCEPT;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (flags.cmd)
                    imq_pkg::CMD_RELOAD:
                    begin
                        ctl.op     = imq_pkg::OP_RELOAD;
                        state_next = S_SWEEP;
                    end
                    imq_pkg::CMD_INSERT:
                    begin
                        if (flags.present)
                        begin
                            ctl.op     = imq_pkg::OP_CK_READ;
                            state_next = S_CK_EVAL;
                        end
                        else if (flags.full)
                        begin
                            ctl.op     = imq_pkg::OP_REPORT;
                            ctl.status = imq_pkg::ST_FULL;
                            fin        = 1'b1;
                        end
                        else
                        begin
                            ctl.op     = imq_pkg::OP_INS_NEW;
                            state_next = S_UP_READ;
                        end
                    end
                    imq_pkg::CMD_REMOVE:
                    begin
                        if (flags.len_zero)
                        begin
                            ctl.op     = imq_pkg::OP_REPORT;
                            ctl.status = imq_pkg::ST_EMPTY;
                            fin        = 1'b1;
                        end
                        else
                        begin
                            ctl.op     = imq_pkg::OP_REMOVE;
                            fin        = flags.len_one;
                            state_next = S_DN_READ;
                        end
                    end
                    imq_pkg::CMD_CHANGE, imq_pkg::CMD_READ:
                    begin
                        if (flags.present)
                        begin
                            ctl.op     = imq_pkg::OP_CK_READ;
                            state_next = S_CK_EVAL;
                        end
                        else
                        begin
                            ctl.op     = imq_pkg::OP_REPORT;
                            ctl.status = imq_pkg::ST_ABSENT;
                            fin        = 1'b1;
                        end
                    end
                    default:
                    begin
                        ctl.op = imq_pkg::OP_REPORT;
                        fin    = 1'b1;
                    end
                endcase
            end
            S_SWEEP:
            begin
                ctl.op = imq_pkg::OP_SWEEP;
                fin    = flags.sweep_last;
            end
            S_CK_EVAL:
            begin
                if (flags.cmd == imq_pkg::CMD_READ)
                begin
                    ctl.op = imq_pkg::OP_RK_DONE;
                    fin    = 1'b1;
                end
                else
                begin
                    ctl.op     = imq_pkg::OP_CK_START;
                    state_next = flags.key_fell ? S_UP_READ : S_DN_READ;
                end
            end
            S_UP_READ:
            begin
                if (flags.hole_root)
                begin
                    ctl.op = imq_pkg::OP_PLACE;
                    fin    = 1'b1;
                end
                else
                begin
                    ctl.op     = imq_pkg::OP_UP_READ;
                    state_next = S_UP_EVAL;
                end
            end
            S_UP_EVAL:
            begin
                if (flags.up_swap)
                begin
                    ctl.op     = imq_pkg::OP_UP_MOVE;
                    state_next = S_UP_READ;
                end
                else
                begin
                    ctl.op = imq_pkg::OP_PLACE;
                    fin    = 1'b1;
                end
            end
            S_DN_READ:
            begin
                if (flags.no_left)
                begin
                    ctl.op = imq_pkg::OP_PLACE;
                    fin    = 1'b1;
                end
                else
                begin
                    ctl.op     = imq_pkg::OP_DN_READ;
                    state_next = S_DN_EVAL;
                end
            end
            S_DN_EVAL:
            begin
                if (flags.dn_swap)
                begin
                    ctl.op     = imq_pkg::OP_DN_MOVE;
                    state_next = S_DN_READ;
                end
                else
                begin
                    ctl.op = imq_pkg::OP_PLACE;
                    fin    = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= fin;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ===== rtl/indexed_min_priority_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// Indexed binary min-heap of (item, key) pairs with key change by item id.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its result beat
// appears in the cycle after the last step, with done high for exactly one
// cycle, and must be captured then. After reset the block is busy while it
// clears the item map. Reload sweeps over all 1024 item ids. Each sift level
// walked needs one registered read and one write of the heap memory.
module indexed_min_priority_queue #(
    parameter int unsigned CAPACITY = 1024
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [imq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [imq_pkg::CFG_W-1:0]             cfg_data,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [2:0]                            cmd,
    input  wire logic [imq_pkg::ID_W-1:0]              item_id,
    input  wire logic signed [imq_pkg::KEY_W-1:0]      key_in,
    output logic                                       done,
    output logic [1:0]                                 status,
    output logic [imq_pkg::ID_W-1:0]                   out_item,
    output logic signed [imq_pkg::KEY_W-1:0]           out_key,
    output logic [imq_pkg::CNT_W-1:0]                  entry_count,
    output logic                                       is_empty
);

    imq_pkg::ctl_t   ctl;
    imq_pkg::flags_t flags;

    imq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    imq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .item_id     (item_id),
        .key_in      (key_in),
        .ctl         (ctl),
        .flags       (flags),
        .status      (status),
        .out_item    (out_item),
        .out_key     (out_key),
        .entry_count (entry_count),
        .is_empty    (is_empty)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_err_key: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != imq_pkg::ST_OK)) |-> (out_key == '0))
        else $error("error beat carries a key");

    a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == imq_pkg::ST_EMPTY)) |-> (out_item == '0) && is_empty)
        else $error("empty status with item or entries");

endmodule
`default_nettype wire
